@@ rtl/edf_pkg.sv @@
// ----------------------------------------------------------------------------
// edf_pkg
// shared types and constants for the earliest-deadline-first tick scheduler
// ----------------------------------------------------------------------------
package edf_pkg;

  // item opcodes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_CLEAR,
    S_SCAN,
    S_WB,
    S_SUM,
    S_RESULT
  } state_t;

  // one slot of the task table
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [15:0] deadline;
  } entry_t;

  localparam logic [23:0] UTIL_MAX   = 24'hFF_FFFF;
  localparam logic [23:0] UTIL_ONE   = 24'h01_0000;
  localparam logic [31:0] TIME_MAX   = 32'hFFFF_FFFF;
  localparam logic [4:0]  TASK_RESET = 5'd16;

endpackage

@@ rtl/edf_if.sv @@
// ----------------------------------------------------------------------------
// edf_in_if / edf_out_if
// valid/ready channels for scheduler commands and scheduler reports
// ----------------------------------------------------------------------------
interface edf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  slot;
  logic [15:0] arrival_time;
  logic [15:0] burst_length;
  logic [15:0] deadline_time;

  modport source (
    output valid, opcode, slot, arrival_time, burst_length, deadline_time,
    input  ready
  );
  modport sink (
    input  valid, opcode, slot, arrival_time, burst_length, deadline_time,
    output ready
  );
endinterface

interface edf_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  running_slot;
  logic        idle;
  logic [31:0] tick_time;
  logic        all_done;
  logic        feasible;

  modport source (
    output valid, running_slot, idle, tick_time, all_done, feasible,
    input  ready
  );
  modport sink (
    input  valid, running_slot, idle, tick_time, all_done, feasible,
    output ready
  );
endinterface

@@ rtl/edf_div.sv @@
// ----------------------------------------------------------------------------
// edf_div
// radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module edf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [15:0] rem;
  logic [15:0] dsr;
  logic [16:0] trial;
  logic        ge;

  // trial remainder with the next dividend bit shifted in
  assign trial = {rem, dvd[31]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd31;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[30:0], ge};
      rem <= ge ? 16'(trial - {1'b0, dsr}) : trial[15:0];
    end
  end

  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (!(start && busy))
        else $error("divider started while busy");
    end
  end

endmodule

@@ rtl/edf_table.sv @@
// ----------------------------------------------------------------------------
// edf_table
// task slot memory, one write and one registered read a cycle, valid per slot
// ----------------------------------------------------------------------------
module edf_table #(
  parameter int SLOTS = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  edf_pkg::entry_t   wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output edf_pkg::entry_t   rd_data
);

  edf_pkg::entry_t mem [SLOTS];
  logic [SLOTS-1:0] valid;
  edf_pkg::entry_t  rd_q;
  logic             rd_v;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // a slot never written since reset or clear reads as empty
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
      rd_v  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_v <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_v ? rd_q : '0;

endmodule

@@ rtl/edf_tick_scheduler.sv @@
// ----------------------------------------------------------------------------
// edf_tick_scheduler
// earliest-deadline-first scheduler over a memory of task slots, one report
// word for every command word
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          opcode, slot, arrival_time,
//                                      burst_length, deadline_time
//  out_ch    out  valid/ready          running_slot, idle, tick_time,
//                                      all_done, feasible
//  cfg       in   cfg_wr_en, no ready  cfg_wr_data = task_count
//
//  timing: a tick scans n = min(task_count, SLOTS) slots; its time from accept
//  to report is set by the single read port of the slot memory (one slot a
//  cycle) plus write-back; a load's time is set by the one-bit-a-cycle divider
//  for the utilisation quotient
//  reset: synchronous, clears sequencer, time, utilisation sum and the slot
//  valid bits at once, so there is no clearing pass
//  stalls: one command word at a time; the report register lets the next
//  command be accepted while the last report still waits on out_ch.ready
// ----------------------------------------------------------------------------
module edf_tick_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [4:0]      cfg_wr_data,
  edf_in_if.sink          in_ch,
  edf_out_if.source       out_ch
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // ---------------------------------------------------------------- state
  edf_pkg::state_t state, state_next;

  logic [4:0]  task_count;
  logic [31:0] current_time;
  logic [23:0] util_sum;

  // captured command word
  logic [1:0]  op_q;
  logic [3:0]  slot_q;
  logic [15:0] arr_q;
  logic [15:0] burst_q;
  logic [15:0] dl_q;
  logic [31:0] time_before;

  // scan bookkeeping
  logic [CW-1:0] issue;
  logic          pend;
  logic [AW-1:0] pend_idx;
  logic          found;
  logic [AW-1:0] best;
  logic [15:0]   best_arr;
  logic [15:0]   best_rem;
  logic [15:0]   best_dl;
  logic [1:0]    nz;        // slots with work left, saturates at two

  // report register
  logic        out_valid;
  logic [3:0]  res_slot;
  logic        res_idle;
  logic [31:0] res_time;
  logic        res_done;
  logic        res_feas;

  logic            in_acc;
  logic            out_free;
  logic [CW-1:0]   count_n;
  logic            scan_done;
  logic            load_ok;
  logic            is_tick;
  logic            is_load;
  logic            is_clear;

  // memory and divider hookup
  logic            mem_wr_en;
  logic [AW-1:0]   mem_wr_addr;
  edf_pkg::entry_t mem_wr_data;
  logic            mem_rd_en;
  edf_pkg::entry_t mem_rd_data;
  logic            div_start;
  logic            div_busy;
  logic [31:0]     div_q;

  logic            eligible;
  logic [23:0]     quot24;
  logic [24:0]     sum25;
  logic            done_now;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == edf_pkg::S_IDLE);

  assign is_tick  = (op_q == edf_pkg::OP_TICK);
  assign is_load  = (op_q == edf_pkg::OP_LOAD);
  assign is_clear = (op_q == edf_pkg::OP_CLEAR);

  // slots taking part, task_count capped at the table size
  assign count_n = (32'(task_count) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(task_count);

  // loads aimed past the table are dropped
  assign load_ok = 32'(slot_q) < 32'(SLOTS);

  assign scan_done = (issue == count_n) && !pend;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= edf_pkg::TASK_RESET;
    end else if (cfg_wr_en) begin
      task_count <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      edf_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.opcode)
            edf_pkg::OP_LOAD:  state_next = edf_pkg::S_LOAD;
            edf_pkg::OP_CLEAR: state_next = edf_pkg::S_CLEAR;
            default:           state_next = edf_pkg::S_SCAN;
          endcase
        end
      end
      edf_pkg::S_LOAD:  state_next = edf_pkg::S_SCAN;
      edf_pkg::S_CLEAR: state_next = edf_pkg::S_RESULT;
      edf_pkg::S_SCAN: begin
        if (scan_done) begin
          if (is_tick) begin
            state_next = edf_pkg::S_WB;
          end else if (is_load) begin
            state_next = edf_pkg::S_SUM;
          end else begin
            state_next = edf_pkg::S_RESULT;
          end
        end
      end
      edf_pkg::S_WB:  state_next = edf_pkg::S_RESULT;
      edf_pkg::S_SUM: begin
        if (!div_busy) begin
          state_next = edf_pkg::S_RESULT;
        end
      end
      edf_pkg::S_RESULT: begin
        if (out_free) begin
          state_next = edf_pkg::S_IDLE;
        end
      end
      default: state_next = edf_pkg::S_IDLE;
    endcase
  end

  // capture the command word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q        <= in_ch.opcode;
      slot_q      <= in_ch.slot;
      arr_q       <= in_ch.arrival_time;
      burst_q     <= in_ch.burst_length;
      dl_q        <= in_ch.deadline_time;
      time_before <= current_time;
    end
  end

  // ---------------------------------------------------------------- slot table
  // a load writes its slot before the scan, a tick writes back the winner
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(slot_q);
    mem_wr_data = '{arrival: arr_q, remaining: burst_q, deadline: dl_q};
    if (state == edf_pkg::S_LOAD) begin
      mem_wr_en = load_ok;
    end else if (state == edf_pkg::S_WB) begin
      mem_wr_en   = found;
      mem_wr_addr = best;
      mem_wr_data = '{arrival: best_arr, remaining: best_rem - 16'd1, deadline: best_dl};
    end
  end

  assign mem_rd_en = (state == edf_pkg::S_SCAN) && (issue != count_n);

  edf_table #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .clear   (state == edf_pkg::S_CLEAR),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (issue[AW-1:0]),
    .rd_data (mem_rd_data)
  );

  // ---------------------------------------------------------------- scan
  // one read issued per cycle, evaluated when the data returns
  assign eligible = ({16'd0, mem_rd_data.arrival} <= current_time)
                 && (mem_rd_data.remaining != 16'd0);

  always_ff @(posedge clk) begin
    if (state == edf_pkg::S_IDLE) begin
      issue <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
      nz    <= '0;
    end else if (state == edf_pkg::S_SCAN) begin
      pend <= mem_rd_en;
      if (mem_rd_en) begin
        issue    <= issue + CW'(1);
        pend_idx <= issue[AW-1:0];
      end
      if (pend) begin
        if (mem_rd_data.remaining != 16'd0 && nz != 2'd2) begin
          nz <= nz + 2'd1;
        end
        // strict less-than keeps the lowest slot on equal deadlines
        if (eligible && (!found || mem_rd_data.deadline < best_dl)) begin
          found    <= 1'b1;
          best     <= pend_idx;
          best_arr <= mem_rd_data.arrival;
          best_rem <= mem_rd_data.remaining;
          best_dl  <= mem_rd_data.deadline;
        end
      end
    end
  end

  // ---------------------------------------------------------------- utilisation
  assign div_start = (state == edf_pkg::S_LOAD) && load_ok && (dl_q != 16'd0);

  edf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({burst_q, 16'd0}),
    .divisor  (dl_q),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // zero deadline or an oversized quotient both saturate
  assign quot24 = ((dl_q == 16'd0) || (div_q[31:24] != 8'd0)) ? edf_pkg::UTIL_MAX
                                                             : div_q[23:0];
  assign sum25  = {1'b0, util_sum} + {1'b0, quot24};

  always_ff @(posedge clk) begin
    if (rst) begin
      util_sum     <= '0;
      current_time <= '0;
    end else begin
      if (state == edf_pkg::S_CLEAR) begin
        util_sum     <= '0;
        current_time <= '0;
      end
      if (state == edf_pkg::S_SUM && !div_busy && load_ok) begin
        util_sum <= sum25[24] ? edf_pkg::UTIL_MAX : sum25[23:0];
      end
      // time saturates at its top value
      if (state == edf_pkg::S_WB && current_time != edf_pkg::TIME_MAX) begin
        current_time <= current_time + 32'd1;
      end
    end
  end

  // ---------------------------------------------------------------- report
  // after a tick the winner may have just used its last unit of work
  assign done_now = is_clear
                 || (nz == 2'd0)
                 || (is_tick && found && nz == 2'd1 && best_rem == 16'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == edf_pkg::S_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == edf_pkg::S_RESULT && out_free) begin
      res_slot <= (is_tick && found) ? 4'(best) : 4'd0;
      res_idle <= !(is_tick && found);
      res_time <= is_clear ? 32'd0 : time_before;
      res_done <= done_now;
      res_feas <= util_sum <= edf_pkg::UTIL_ONE;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.running_slot = res_slot;
  assign out_ch.idle         = res_idle;
  assign out_ch.tick_time    = res_time;
  assign out_ch.all_done     = res_done;
  assign out_ch.feasible     = res_feas;

  // ---------------------------------------------------------------- checks
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    state == edf_pkg::S_SCAN |-> issue <= count_n)
    else $error("scan issued past the counted slots");

  a_wb_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == edf_pkg::S_WB && found) |-> best_rem != 16'd0)
    else $error("write-back picked a slot with no work");

  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    state != edf_pkg::S_CLEAR |=> current_time >= $past(current_time))
    else $error("time went backwards without a clear");

  a_util_stable: assert property (@(posedge clk) disable iff (rst)
    (state != edf_pkg::S_SUM && state != edf_pkg::S_CLEAR) |=> $stable(util_sum))
    else $error("utilisation sum changed outside a load or clear");

  a_sum_after_div: assert property (@(posedge clk) disable iff (rst)
    state == edf_pkg::S_LOAD |=> !(state == edf_pkg::S_RESULT))
    else $error("load reported before its quotient was ready");

endmodule

@@ tb/edf_tick_scheduler_checker.sv @@
// ----------------------------------------------------------------------------
// edf_tick_scheduler_checker
// watches the command and report channels, predicts every report from its
// own copy of the task table and compares it with what the scheduler returns
// ----------------------------------------------------------------------------
module edf_tick_scheduler_checker #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  edf_in_if           cmd,
  edf_out_if          rpt,
  output int unsigned fail_count,
  output int unsigned reports_seen,
  output int unsigned busy_ticks
);

  localparam int SHOWN_MAX = 10;

  typedef struct packed {
    logic [3:0]  running_slot;
    logic        idle;
    logic [31:0] tick_time;
    logic        all_done;
    logic        feasible;
  } report_t;

  logic [15:0] arrival_tab   [SLOTS];
  logic [15:0] remaining_tab [SLOTS];
  logic [15:0] deadline_tab  [SLOTS];
  logic [31:0] now_tick;
  logic [23:0] util_sum;
  logic [4:0]  task_count;

  report_t     awaited_reports [$];
  int unsigned n_bad  = 0;
  int unsigned n_seen = 0;
  int unsigned n_busy = 0;

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      arrival_tab[i]   = '0;
      remaining_tab[i] = '0;
      deadline_tab[i]  = '0;
    end
    now_tick = '0;
    util_sum = '0;
  endfunction

  // applies one command word to the table and returns the report it should give
  function automatic report_t predict_report(input edf_pkg::opcode_t op,
                                             input logic [3:0] slot,
                                             input logic [15:0] arr,
                                             input logic [15:0] burst,
                                             input logic [15:0] dl);
    report_t     r;
    int unsigned n;
    logic        found;
    int unsigned best;
    logic [15:0] best_dl;
    logic [63:0] quot;
    logic [63:0] total;
    r              = '0;
    r.idle         = 1'b1;
    r.tick_time    = now_tick;
    found          = 1'b0;
    best           = 0;
    best_dl        = '0;
    n = (task_count > SLOTS) ? SLOTS : task_count;
    case (op)
      edf_pkg::OP_LOAD: begin
        if (slot < SLOTS) begin
          arrival_tab[slot]   = arr;
          remaining_tab[slot] = burst;
          deadline_tab[slot]  = dl;
          if (dl == '0) quot = 64'(edf_pkg::UTIL_MAX);
          else          quot = {32'd0, burst, 16'd0} / dl;
          if (quot > 64'(edf_pkg::UTIL_MAX)) quot = 64'(edf_pkg::UTIL_MAX);
          total    = 64'(util_sum) + quot;
          util_sum = (total > 64'(edf_pkg::UTIL_MAX)) ? edf_pkg::UTIL_MAX : total[23:0];
        end
      end
      edf_pkg::OP_TICK: begin
        for (int i = 0; i < n; i++) begin
          if (32'(arrival_tab[i]) <= now_tick && remaining_tab[i] != '0 &&
              (!found || deadline_tab[i] < best_dl)) begin
            found   = 1'b1;
            best    = i;
            best_dl = deadline_tab[i];
          end
        end
        if (found) begin
          remaining_tab[best] = remaining_tab[best] - 16'd1;
          r.running_slot      = best[3:0];
          r.idle              = 1'b0;
        end
        if (now_tick != edf_pkg::TIME_MAX) now_tick = now_tick + 32'd1;
      end
      edf_pkg::OP_CLEAR: begin
        clear_table();
        r.tick_time = '0;
      end
      default: ;
    endcase
    r.all_done = 1'b1;
    for (int i = 0; i < n; i++)
      if (remaining_tab[i] != '0) r.all_done = 1'b0;
    r.feasible = (util_sum <= edf_pkg::UTIL_ONE);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    report_t exp_r;
    report_t got;
    logic    bad;
    if (rst) begin
      clear_table();
      task_count = edf_pkg::TASK_RESET;
      awaited_reports.delete();
    end else begin
      if (cfg_wr_en === 1'b1) task_count = cfg_wr_data;
      if ((cmd.valid & cmd.ready) === 1'b1) begin
        exp_r = predict_report(edf_pkg::opcode_t'(cmd.opcode), cmd.slot, cmd.arrival_time,
                               cmd.burst_length, cmd.deadline_time);
        if (!exp_r.idle) n_busy++;
        awaited_reports.push_back(exp_r);
      end
      if ((rpt.valid & rpt.ready) === 1'b1) begin
        got.running_slot = rpt.running_slot;
        got.idle         = rpt.idle;
        got.tick_time    = rpt.tick_time;
        got.all_done     = rpt.all_done;
        got.feasible     = rpt.feasible;
        n_seen++;
        if (awaited_reports.size() == 0) begin
          n_bad++;
          if (n_bad <= SHOWN_MAX)
            $display("report word %0d with nothing awaited: slot=%0d idle=%b time=%0d",
                     n_seen, got.running_slot, got.idle, got.tick_time,
                     " done=%b ok=%b", got.all_done, got.feasible);
        end else begin
          exp_r = awaited_reports.pop_front();
          bad = (got.running_slot !== exp_r.running_slot) || (got.idle !== exp_r.idle) ||
                (got.tick_time !== exp_r.tick_time) || (got.all_done !== exp_r.all_done) ||
                (got.feasible !== exp_r.feasible);
          if (bad) begin
            n_bad++;
            if (n_bad <= SHOWN_MAX) begin
              $display("report word %0d mismatch", n_seen);
              $display("  expected slot=%0d idle=%b time=%0d done=%b feasible=%b",
                       exp_r.running_slot, exp_r.idle, exp_r.tick_time, exp_r.all_done,
                       exp_r.feasible);
              $display("  actual   slot=%0d idle=%b time=%0d done=%b feasible=%b",
                       got.running_slot, got.idle, got.tick_time, got.all_done, got.feasible);
            end
          end
        end
      end
    end
    fail_count   <= n_bad;
    reports_seen <= n_seen;
    busy_ticks   <= n_busy;
  end

endmodule

@@ tb/edf_tick_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// edf_tick_scheduler_tb
// drives load, tick, clear and unused command words into the scheduler under
// a range of task-count settings, with random gaps on both channels; the
// checker beside the block predicts and compares every report word
// ----------------------------------------------------------------------------
module edf_tick_scheduler_tb;

  localparam int SLOTS       = 16;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 133;
  // a load runs its divider before it can report, so this covers any late word
  localparam int TAIL_CYCLES = 50;
  // slowest legal wait between two handshakes is a load plus a long ready
  // stall; this is many times that
  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;
  bit          calm;

  int unsigned words_sent = 0;
  int unsigned n_load     = 0;
  int unsigned n_tick     = 0;
  int unsigned n_clear    = 0;
  int unsigned n_unused   = 0;
  int unsigned n_settings = 0;
  int unsigned est_time   = 0;
  int unsigned quiet_cycles = 0;

  int unsigned fail_count;
  int unsigned reports_seen;
  int unsigned busy_ticks;

  edf_in_if  cmd_ch ();
  edf_out_if rpt_ch ();

  edf_tick_scheduler #(
    .SLOTS (SLOTS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (cmd_ch),
    .out_ch      (rpt_ch)
  );

  edf_tick_scheduler_checker #(
    .SLOTS (SLOTS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd_ch),
    .rpt          (rpt_ch),
    .fail_count   (fail_count),
    .reports_seen (reports_seen),
    .busy_ticks   (busy_ticks)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // report side back-pressure: random stalls unless in a calm stretch
  always @(posedge clk) begin
    rpt_ch.ready <= calm || ($urandom_range(99) >= 24);
  end

  // watchdog on handshakes, not on total run time
  always @(posedge clk) begin
    if ((cmd_ch.valid & cmd_ch.ready) === 1'b1 || (rpt_ch.valid & rpt_ch.ready) === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("edf_tick_scheduler verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one command word and hold it until taken; valid stays high for a
  // following word unless a gap is drawn
  task automatic send_word(input edf_pkg::opcode_t op, input logic [3:0] slot,
                           input logic [15:0] arr, input logic [15:0] burst,
                           input logic [15:0] dl);
    while (!calm && $urandom_range(99) < 24) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.opcode        <= op;
    cmd_ch.slot          <= slot;
    cmd_ch.arrival_time  <= arr;
    cmd_ch.burst_length  <= burst;
    cmd_ch.deadline_time <= dl;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    words_sent++;
    // keep a rough idea of scheduler time so arrivals land near it
    case (op)
      edf_pkg::OP_LOAD:  n_load++;
      edf_pkg::OP_TICK:  begin n_tick++; est_time++; end
      edf_pkg::OP_CLEAR: begin n_clear++; est_time = 0; end
      default:           n_unused++;
    endcase
  endtask

  // stop sending and wait for every outstanding report word
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (reports_seen != words_sent) @(posedge clk);
  endtask

  task automatic set_task_count(input logic [4:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    n_settings++;
  endtask

  // any opcode with every field drawn over its full width
  task automatic send_noise(input edf_pkg::opcode_t op);
    send_word(op, 4'($urandom_range(15)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)), 16'($urandom_range(65535)));
  endtask

  // a small task set that can actually run: arrivals near now, short bursts,
  // deadlines a little ahead, then a run of ticks to work through it
  task automatic run_scenario(input int unsigned active);
    int unsigned loads;
    int unsigned ticks;
    logic [3:0]  s;
    logic [15:0] burst;
    if ($urandom_range(2) == 0) send_noise(edf_pkg::OP_CLEAR);
    loads = $urandom_range(5, 1);
    repeat (loads) begin
      if ($urandom_range(1) == 0) s = 4'($urandom_range(15));
      else                        s = 4'($urandom_range(active - 1));
      burst = 16'($urandom_range(6, 1));
      send_word(edf_pkg::OP_LOAD, s, 16'(est_time + $urandom_range(6)), burst,
                16'(est_time + burst + $urandom_range(40)));
    end
    ticks = $urandom_range(24, 1);
    repeat (ticks) send_noise(edf_pkg::OP_TICK);
  endtask

  initial begin
    logic [4:0]  settings [PHASES];
    int unsigned active;
    int unsigned phase_end;
    int unsigned pick;
    bit          paused;

    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.opcode        <= edf_pkg::OP_LOAD;
    cmd_ch.slot          <= '0;
    cmd_ch.arrival_time  <= '0;
    cmd_ch.burst_length  <= '0;
    cmd_ch.deadline_time <= '0;
    calm                 <= 1'b0;
    paused               = 1'b0;

    // extremes first: full table, single slot, none, and values past the table
    settings[0] = 5'd16;
    settings[1] = 5'd1;
    settings[2] = 5'd0;
    settings[3] = 5'd31;
    settings[4] = 5'd17;
    settings[5] = 5'd6;
    settings[6] = 5'd16;
    settings[7] = 5'($urandom_range(16, 1));
    settings[8] = 5'($urandom_range(16, 1));
    settings[9] = 5'd11;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part, task count at its reset value
    // tick on an empty table
    send_word(edf_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 16'd0);
    // three tasks: the later one with the tighter deadline runs ahead of slot 0,
    // and slot 15 finishes before slot 7, with the equal deadline, arrives
    send_word(edf_pkg::OP_LOAD, 4'd0, 16'd0, 16'd3, 16'd10);
    send_word(edf_pkg::OP_LOAD, 4'd15, 16'd0, 16'd1, 16'd5);
    send_word(edf_pkg::OP_LOAD, 4'd7, 16'd2, 16'd2, 16'd5);
    repeat (6) send_word(edf_pkg::OP_TICK, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // zero burst: never selected, adds nothing
    send_word(edf_pkg::OP_LOAD, 4'd3, 16'd0, 16'd0, 16'd100);
    // zero deadline saturates the quotient and the sum
    send_word(edf_pkg::OP_LOAD, 4'd4, 16'hFFFF, 16'hFFFF, 16'd0);
    // reload of the same slot adds its quotient again
    send_word(edf_pkg::OP_LOAD, 4'd4, 16'hFFFF, 16'hFFFF, 16'd1);
    send_word(edf_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 16'd0);
    // unused opcode only reports
    send_word(edf_pkg::OP_NONE, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(edf_pkg::OP_CLEAR, 4'd0, 16'd0, 16'd0, 16'd0);
    // field extremes after a clear
    send_word(edf_pkg::OP_LOAD, 4'd9, 16'd0, 16'hFFFF, 16'hFFFF);
    send_word(edf_pkg::OP_LOAD, 4'd1, 16'hFFFF, 16'd1, 16'd1);
    repeat (2) send_word(edf_pkg::OP_TICK, 4'd0, 16'd0, 16'd0, 16'd0);
    send_word(edf_pkg::OP_CLEAR, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // random phases, each under its own task count, written only when idle
    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_task_count(settings[p]);
      // one phase runs with no gaps on either side
      calm <= (p == 2);
      active = (settings[p] == 5'd0 || settings[p] > SLOTS) ? SLOTS : settings[p];
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        // hold the sender mid-phase until the block has caught up
        if (p == 4 && !paused && words_sent + PHASE_WORDS / 2 >= phase_end) begin
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 8)       send_noise(edf_pkg::OP_LOAD);
        else if (pick < 11) send_noise(edf_pkg::OP_NONE);
        else if (pick < 14) send_noise(edf_pkg::OP_CLEAR);
        else                run_scenario(active);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d command words: %0d loads, %0d ticks (%0d ran a task),",
             words_sent, n_load, n_tick, busy_ticks,
             " %0d clears, %0d unused", n_clear, n_unused);
    $display("over %0d task-count settings from 0 to 31, %0d report words compared",
             n_settings, reports_seen);
    if (fail_count == 0 && reports_seen == words_sent) begin
      $display("edf_tick_scheduler verification clean");
    end else begin
      $display("edf_tick_scheduler verification failed");
    end
    $finish;
  end

endmodule
